[rtl/dvrt_pkg.sv]
// shared constants, codes and controller/datapath interface types
`default_nettype none
package dvrt_pkg;

   localparam int TABLE_ENTRIES = 32;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
   localparam int ADDR_W        = 32;
   localparam int COST_W        = 20;
   localparam int OP_W          = 3;
   localparam int STATUS_W      = 2;

   localparam logic [COST_W-1:0] COST_INF = COST_W'(1000000);

   // operation codes
   localparam logic [OP_W-1:0] OP_LINK   = 3'd0;
   localparam logic [OP_W-1:0] OP_COST   = 3'd1;
   localparam logic [OP_W-1:0] OP_HEADER = 3'd2;
   localparam logic [OP_W-1:0] OP_ENTRY  = 3'd3;
   localparam logic [OP_W-1:0] OP_DUMP   = 3'd4;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_DUMP    = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic load;       // latch a new transaction
      logic find;       // register table lookup result
      logic key_b;      // look up the second endpoint
      logic exec;       // apply the update
      logic respond;    // emit the single result
      logic dump_step;  // emit one table entry
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic others_link;  // link between two other nodes, needs two lookups
      logic is_dump;
      logic count_zero;
      logic dump_last;
   } sts_type;

endpackage
`default_nettype wire

[rtl/distance_vector_route_table.sv]
// top level of the distance-vector route table
`default_nettype none
// A transaction is taken when start is high and busy is low. Every operation but a
// dump gives one result; a dump gives one result per table entry (one result when
// the table is empty). Results appear for a single cycle on rsp_strobe and cannot be
// held off, so the receiver must take every strobe. A transaction passes through
// accept, a parallel lookup of all entries and write-back; a link between two other
// nodes goes through lookup and write-back once per endpoint; a dump then emits its
// entries one per cycle through the single table read port. The own address register
// may be written at any idle time through csr_wr_en and csr_wr_data.
module distance_vector_route_table (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [dvrt_pkg::ADDR_W-1:0]   csr_wr_data,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [dvrt_pkg::OP_W-1:0]     req_op,
   input  wire logic [dvrt_pkg::ADDR_W-1:0]   req_addr_a,
   input  wire logic [dvrt_pkg::ADDR_W-1:0]   req_addr_b,
   input  wire logic [dvrt_pkg::COST_W-1:0]   req_link_cost,
   output logic                               rsp_strobe,
   output logic [dvrt_pkg::STATUS_W-1:0]      rsp_status,
   output logic [dvrt_pkg::ADDR_W-1:0]        rsp_entry_destination,
   output logic [dvrt_pkg::ADDR_W-1:0]        rsp_entry_next_hop,
   output logic                               rsp_entry_hop_known,
   output logic [dvrt_pkg::COST_W-1:0]        rsp_entry_cost,
   output logic                               rsp_entry_is_neighbour,
   output logic                               rsp_last
);
   import dvrt_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencer
   dvrt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   // table and result path
   dvrt_datapath u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .csr_wr_en              (csr_wr_en),
      .csr_wr_data            (csr_wr_data),
      .req_op                 (req_op),
      .req_addr_a             (req_addr_a),
      .req_addr_b             (req_addr_b),
      .req_link_cost          (req_link_cost),
      .cmd                    (cmd),
      .sts                    (sts),
      .rsp_strobe             (rsp_strobe),
      .rsp_status             (rsp_status),
      .rsp_entry_destination  (rsp_entry_destination),
      .rsp_entry_next_hop     (rsp_entry_next_hop),
      .rsp_entry_hop_known    (rsp_entry_hop_known),
      .rsp_entry_cost         (rsp_entry_cost),
      .rsp_entry_is_neighbour (rsp_entry_is_neighbour),
      .rsp_last               (rsp_last)
   );

endmodule
`default_nettype wire

[rtl/dvrt_ctrl.sv]
// sequencing state machine for lookup, update and dump
`default_nettype none
module dvrt_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   input  dvrt_pkg::sts_type    sts,
   output dvrt_pkg::cmd_type    cmd
);
   import dvrt_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_FIND = 4'b0010,
      S_EXEC = 4'b0100,
      S_DUMP = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      pass_ff, pass_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      pass_in  = pass_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               pass_in  = 1'b0;
               state_in = S_FIND;
            end
         end
         S_FIND: begin
            cmd.find  = 1'b1;
            cmd.key_b = pass_ff;
            state_in  = S_EXEC;
         end
         S_EXEC: begin
            cmd.exec  = 1'b1;
            cmd.key_b = pass_ff;
            if (sts.others_link && !pass_ff) begin
               pass_in  = 1'b1;
               state_in = S_FIND;
            end else if (sts.is_dump && !sts.count_zero) begin
               state_in = S_DUMP;
            end else begin
               cmd.respond = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_DUMP: begin
            cmd.dump_step = 1'b1;
            if (sts.dump_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pass_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule
`default_nettype wire

[rtl/dvrt_datapath.sv]
// route table storage, parallel lookup, update logic and result register
`default_nettype none
module dvrt_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [dvrt_pkg::ADDR_W-1:0]   csr_wr_data,
   input  wire logic [dvrt_pkg::OP_W-1:0]     req_op,
   input  wire logic [dvrt_pkg::ADDR_W-1:0]   req_addr_a,
   input  wire logic [dvrt_pkg::ADDR_W-1:0]   req_addr_b,
   input  wire logic [dvrt_pkg::COST_W-1:0]   req_link_cost,
   input  dvrt_pkg::cmd_type                  cmd,
   output dvrt_pkg::sts_type                  sts,
   output logic                               rsp_strobe,
   output logic [dvrt_pkg::STATUS_W-1:0]      rsp_status,
   output logic [dvrt_pkg::ADDR_W-1:0]        rsp_entry_destination,
   output logic [dvrt_pkg::ADDR_W-1:0]        rsp_entry_next_hop,
   output logic                               rsp_entry_hop_known,
   output logic [dvrt_pkg::COST_W-1:0]        rsp_entry_cost,
   output logic                               rsp_entry_is_neighbour,
   output logic                               rsp_last
);
   import dvrt_pkg::*;

   // configuration and latched transaction
   logic [ADDR_W-1:0] own_ff;
   logic [OP_W-1:0]   op_ff;
   logic [ADDR_W-1:0] a_ff;
   logic [ADDR_W-1:0] b_ff;
   logic [COST_W-1:0] cost_ff;

   // table and bookkeeping
   logic [ADDR_W-1:0] dest_ff  [TABLE_ENTRIES];
   logic [ADDR_W-1:0] hop_ff   [TABLE_ENTRIES];
   logic              known_ff [TABLE_ENTRIES];
   logic [COST_W-1:0] rcost_ff [TABLE_ENTRIES];
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [COST_W-1:0] base_ff;
   logic [ADDR_W-1:0] nbr_ff;
   logic              active_ff;
   logic              hit_ff, hit_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              fail_ff;
   logic [IDX_W-1:0]  dump_idx_ff;

   // result register
   logic                rsp_strobe_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [ADDR_W-1:0]   rsp_dest_ff;
   logic [ADDR_W-1:0]   rsp_hop_ff;
   logic                rsp_known_ff;
   logic [COST_W-1:0]   rsp_cost_ff;
   logic                rsp_nbr_ff;
   logic                rsp_last_ff;

   logic              a_own, b_own, direct, full;
   logic [ADDR_W-1:0] peer, key;
   logic [COST_W:0]   sum_wide;
   logic [COST_W-1:0] sum;
   logic [COST_W-1:0] cost_clamped;
   logic [IDX_W-1:0]  rd_idx;
   logic [ADDR_W-1:0] rd_dest, rd_hop;
   logic              rd_known;
   logic [COST_W-1:0] rd_cost;

   logic [STATUS_W-1:0] exec_status;
   logic                fail_now;
   logic                wr_en, wr_dest, wr_hop, wr_known, wr_cost, append;
   logic [IDX_W-1:0]    wr_idx;
   logic [ADDR_W-1:0]   wd_dest, wd_hop;
   logic                wd_known;
   logic [COST_W-1:0]   wd_cost;
   logic                dump_last;

   // transaction classification
   assign a_own  = (a_ff == own_ff);
   assign b_own  = (b_ff == own_ff);
   assign direct = a_own || b_own;
   assign peer   = a_own ? b_ff : a_ff;
   assign full   = (count_ff == CNT_W'(TABLE_ENTRIES));

   // lookup key
   always_comb begin
      if (cmd.key_b) begin
         key = b_ff;
      end else if ((op_ff == OP_LINK || op_ff == OP_COST) && direct) begin
         key = peer;
      end else begin
         key = a_ff;
      end
   end

   // parallel compare, destinations are unique so the hit index is an or of matches
   always_comb begin
      logic m;
      hit_in = 1'b0;
      idx_in = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         m      = (CNT_W'(i) < count_ff) && (dest_ff[i] == key);
         hit_in = hit_in | m;
         idx_in = idx_in | (m ? IDX_W'(i) : '0);
      end
   end

   // single table read port
   assign rd_idx   = cmd.dump_step ? dump_idx_ff : idx_ff;
   assign rd_dest  = dest_ff[rd_idx];
   assign rd_hop   = hop_ff[rd_idx];
   assign rd_known = known_ff[rd_idx];
   assign rd_cost  = rcost_ff[rd_idx];

   // saturating advertised cost
   assign sum_wide = {1'b0, cost_ff} + {1'b0, base_ff};
   assign sum      = (sum_wide > {1'b0, COST_INF}) ? COST_INF : sum_wide[COST_W-1:0];

   assign cost_clamped = (req_link_cost > COST_INF) ? COST_INF : req_link_cost;

   // update decision
   always_comb begin
      exec_status = ST_IGNORED;
      fail_now    = 1'b0;
      wr_dest     = 1'b0;
      wr_hop      = 1'b0;
      wr_known    = 1'b0;
      wr_cost     = 1'b0;
      append      = 1'b0;
      wr_idx      = idx_ff;
      wd_dest     = key;
      wd_hop      = peer;
      wd_known    = 1'b1;
      wd_cost     = cost_ff;
      unique case (op_ff)
         OP_LINK: begin
            if (direct) begin
               if (hit_ff) begin
                  wr_hop      = 1'b1;
                  wr_known    = 1'b1;
                  wr_cost     = 1'b1;
                  exec_status = ST_DONE;
               end else if (!full) begin
                  append      = 1'b1;
                  exec_status = ST_DONE;
               end else begin
                  exec_status = ST_FULL;
               end
            end else begin
               if (!hit_ff) begin
                  if (!full) begin
                     append   = 1'b1;
                     wd_hop   = '0;
                     wd_known = 1'b0;
                     wd_cost  = COST_INF;
                  end else begin
                     fail_now = 1'b1;
                  end
               end
               exec_status = (fail_now || (cmd.key_b && fail_ff)) ? ST_FULL : ST_DONE;
            end
         end
         OP_COST: begin
            if (direct && hit_ff) begin
               wr_cost     = 1'b1;
               exec_status = ST_DONE;
            end
         end
         OP_HEADER: begin
            exec_status = a_own ? ST_IGNORED : ST_DONE;
         end
         OP_ENTRY: begin
            if (active_ff && hit_ff && (sum < rd_cost)) begin
               wr_hop      = 1'b1;
               wr_known    = 1'b1;
               wr_cost     = 1'b1;
               wd_hop      = nbr_ff;
               wd_cost     = sum;
               exec_status = ST_DONE;
            end
         end
         OP_DUMP: begin
            exec_status = ST_DONE;
         end
         default: begin
            exec_status = ST_IGNORED;
         end
      endcase
      if (append) begin
         wr_idx   = count_ff[IDX_W-1:0];
         wr_dest  = 1'b1;
         wr_hop   = 1'b1;
         wr_known = 1'b1;
         wr_cost  = 1'b1;
      end
   end

   assign wr_en    = cmd.exec;
   assign count_in = count_ff + CNT_W'(1);

   // table write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         if (wr_dest) begin
            dest_ff[wr_idx] <= wd_dest;
         end
         if (wr_hop) begin
            hop_ff[wr_idx] <= wd_hop;
         end
         if (wr_known) begin
            known_ff[wr_idx] <= wd_known;
         end
         if (wr_cost) begin
            rcost_ff[wr_idx] <= wd_cost;
         end
      end
   end

   // control state: configuration, count, advertisement latch
   always_ff @(posedge clock) begin
      if (reset) begin
         own_ff    <= '0;
         count_ff  <= '0;
         base_ff   <= COST_INF;
         nbr_ff    <= '0;
         active_ff <= 1'b0;
         fail_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            own_ff <= csr_wr_data;
         end
         if (wr_en && append) begin
            count_ff <= count_in;
         end
         if (wr_en && op_ff == OP_HEADER) begin
            nbr_ff    <= a_ff;
            active_ff <= 1'b1;
            base_ff   <= (!a_own && hit_ff) ? rd_cost : COST_INF;
         end
         if (wr_en && !cmd.key_b) begin
            fail_ff <= fail_now;
         end
      end
   end

   // transaction latch and lookup result
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_op;
         a_ff    <= req_addr_a;
         b_ff    <= req_addr_b;
         cost_ff <= cost_clamped;
      end
      if (cmd.find) begin
         hit_ff <= hit_in;
         idx_ff <= idx_in;
      end
   end

   // dump walk
   assign dump_last = ((CNT_W'(dump_idx_ff) + CNT_W'(1)) == count_ff);

   always_ff @(posedge clock) begin
      if (reset || cmd.load) begin
         dump_idx_ff <= '0;
      end else if (cmd.dump_step) begin
         dump_idx_ff <= dump_idx_ff + IDX_W'(1);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.respond || cmd.dump_step;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.dump_step) begin
         rsp_status_ff <= ST_DUMP;
         rsp_dest_ff   <= rd_dest;
         rsp_hop_ff    <= rd_known ? rd_hop : '0;
         rsp_known_ff  <= rd_known;
         rsp_cost_ff   <= rd_cost;
         rsp_nbr_ff    <= rd_known && (rd_hop == rd_dest);
         rsp_last_ff   <= dump_last;
      end else if (cmd.respond) begin
         rsp_status_ff <= exec_status;
         rsp_dest_ff   <= '0;
         rsp_hop_ff    <= '0;
         rsp_known_ff  <= 1'b0;
         rsp_cost_ff   <= '0;
         rsp_nbr_ff    <= 1'b0;
         rsp_last_ff   <= 1'b1;
      end
   end

   // status to controller
   assign sts.others_link = (op_ff == OP_LINK) && !direct;
   assign sts.is_dump     = (op_ff == OP_DUMP);
   assign sts.count_zero  = (count_ff == '0);
   assign sts.dump_last   = dump_last;

   assign rsp_strobe             = rsp_strobe_ff;
   assign rsp_status             = rsp_status_ff;
   assign rsp_entry_destination  = rsp_dest_ff;
   assign rsp_entry_next_hop     = rsp_hop_ff;
   assign rsp_entry_hop_known    = rsp_known_ff;
   assign rsp_entry_cost         = rsp_cost_ff;
   assign rsp_entry_is_neighbour = rsp_nbr_ff;
   assign rsp_last               = rsp_last_ff;

endmodule
`default_nettype wire
